/* rtl/core/frc_pkg.sv */
package frc_pkg;

    localparam int unsigned MAX_LEN = 32;

    localparam logic [7:0]  START_MARK = 8'h24;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    // shortest frame that carries a CRC
    localparam logic [7:0] MIN_CRC_LEN = 8'd5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CRC_BAD   = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_TOO_SHORT = 2'd3
    } frc_status_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  data;
        logic [7:0]  index;
        logic        last;
        frc_status_t status;
    } frc_result_t;

    // reflected CRC-16, one byte, bits unrolled
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/frc_frame_fsm.sv */
module frc_frame_fsm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    output frc_pkg::frc_result_t result
);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SKIP    = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

    localparam logic [7:0] MAX_LEN_B = 8'(frc_pkg::MAX_LEN);

    phase_t      phase_reg, phase_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;

    // frame context seen by the current byte (fresh on the length byte)
    logic        in_frame;
    logic [7:0]  len_cur, idx_cur, lo_cur, hi_cur;
    logic [15:0] crc_cur;
    logic [7:0]  target;
    logic        last;
    frc_pkg::frc_status_t status;

    always_comb
    begin
        in_frame = 1'b0;
        len_cur  = len_reg;
        idx_cur  = count_reg;
        crc_cur  = crc_reg;
        lo_cur   = crc_lo_reg;
        hi_cur   = crc_hi_reg;
        case (phase_reg)
            PH_SKIP:
            begin
                if (rx_byte != frc_pkg::START_MARK) begin
                    in_frame = 1'b1;
                    len_cur  = rx_byte;
                    idx_cur  = 8'd0;
                    crc_cur  = frc_pkg::CRC_INIT;
                    lo_cur   = 8'd0;
                    hi_cur   = 8'd0;
                end
            end
            PH_COLLECT: in_frame = 1'b1;
            default:    in_frame = 1'b0;
        endcase
    end

    always_comb
    begin
        target = (len_cur == 8'd0 || len_cur > MAX_LEN_B) ? MAX_LEN_B : len_cur;
        last   = ({1'b0, idx_cur} + 9'd1) >= {1'b0, target};

        crc_next    = crc_cur;
        crc_lo_next = lo_cur;
        crc_hi_next = hi_cur;
        if (({1'b0, idx_cur} + 9'd4) < {1'b0, len_cur}) begin
            crc_next = frc_pkg::crc16_byte(crc_cur, rx_byte);
        end
        if (len_cur >= frc_pkg::MIN_CRC_LEN && idx_cur == len_cur - 8'd3) begin
            crc_lo_next = rx_byte;
        end
        if (len_cur >= frc_pkg::MIN_CRC_LEN && idx_cur == len_cur - 8'd2) begin
            crc_hi_next = rx_byte;
        end

        if (len_cur > MAX_LEN_B) begin
            status = frc_pkg::ST_TOO_LONG;
        end
        else if (len_cur < frc_pkg::MIN_CRC_LEN) begin
            status = frc_pkg::ST_TOO_SHORT;
        end
        else if ({hi_cur, lo_cur} == crc_cur) begin
            status = frc_pkg::ST_OK;
        end
        else begin
            status = frc_pkg::ST_CRC_BAD;
        end

        len_next   = len_cur;
        count_next = last ? 8'd0 : idx_cur + 8'd1;
        if (in_frame) begin
            phase_next = last ? PH_HUNT : PH_COLLECT;
        end
        else if (rx_byte == frc_pkg::START_MARK) begin
            phase_next = PH_SKIP;
        end
        else begin
            phase_next = PH_HUNT;
        end

        result.valid  = take && in_frame;
        result.data   = rx_byte;
        result.index  = idx_cur;
        result.last   = last;
        result.status = last ? status : frc_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_HUNT;
            len_reg    <= 8'd0;
            count_reg  <= 8'd0;
            crc_reg    <= frc_pkg::CRC_INIT;
            crc_lo_reg <= 8'd0;
            crc_hi_reg <= 8'd0;
        end
        else if (take) begin
            phase_reg <= phase_next;
            if (in_frame) begin
                len_reg    <= len_next;
                count_reg  <= count_next;
                crc_reg    <= crc_next;
                crc_lo_reg <= crc_lo_next;
                crc_hi_reg <= crc_hi_next;
            end
        end
    end

endmodule

/* rtl/core/frame_receiver_crc_checker_unit.sv */
// Channel   Handshake             Payload
// rx        rx_valid / rx_ready   rx_byte[7:0]
// res       res_valid / res_ready data_byte[7:0], byte_index[7:0], frame_end, frame_status[1:0]
//
// One rx transaction per cycle while the skid register is empty; a taken frame byte is registered
// into the output register, or into the skid when res is stalled. The length, CRC and status logic
// is a single byte-wide pass ahead of the result register, so the CRC-16 update (eight unrolled
// shift steps) sets the cycle time. Reset (rst_n low, asynchronous) returns to hunting for '$'
// with the CRC at 0xFFFF. A stalled res side is absorbed by a one-entry skid register; rx_ready
// drops only once that is also full. Marker and idle bytes never need a result slot.
module frame_receiver_crc_checker_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] data_byte,
    output logic [7:0] byte_index,
    output logic       frame_end,
    output logic [1:0] frame_status
);

    frc_pkg::frc_result_t fsm_result;
    frc_pkg::frc_result_t out_reg;   // visible result
    frc_pkg::frc_result_t skid_reg;  // overflow when res is stalled

    logic take;
    logic res_fire;

    assign rx_ready = !skid_reg.valid;
    assign take     = rx_valid && rx_ready;
    assign res_fire = out_reg.valid && res_ready;

    frc_frame_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .result  (fsm_result)
    );

    // Output register plus skid: while the skid holds a result no rx transaction is taken,
    // so the skid drains into the output register as soon as the consumer takes one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else if (skid_reg.valid) begin
            if (res_fire) begin
                out_reg        <= skid_reg;
                skid_reg.valid <= 1'b0;
            end
        end
        else if (fsm_result.valid) begin
            if (!out_reg.valid || res_fire) begin
                out_reg <= fsm_result;
            end
            else begin
                skid_reg <= fsm_result;
            end
        end
        else if (res_fire) begin
            out_reg.valid <= 1'b0;
        end
    end

    assign res_valid    = out_reg.valid;
    assign data_byte    = out_reg.data;
    assign byte_index   = out_reg.index;
    assign frame_end    = out_reg.last;
    assign frame_status = out_reg.status;

    // skid only ever fills behind a waiting output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_reg.valid |-> out_reg.valid)
        else $error("skid holds a result with the output register empty");

    // status is only reported on the closing byte
    a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !frame_end) |-> (frame_status == frc_pkg::ST_OK))
        else $error("frame status set on a byte that does not end the frame");

    // frame never runs past the length cap
    a_index_cap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ({24'd0, byte_index} < frc_pkg::MAX_LEN))
        else $error("byte index beyond maximum frame length");

    // a result ending a stall at the skid must reach the output next cycle
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_reg.valid && res_ready) |=> (res_valid && !skid_reg.valid))
        else $error("skid result not moved to the output");

endmodule

/* tb/frc_tb_pkg.sv */
`timescale 1ns / 100ps

package frc_tb_pkg;

    import frc_pkg::*;

    // CRC-16 (reflected) advanced by one byte, a bit at a time, LSB first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb  = acc[0] ^ b[i];
            acc = acc >> 1;
            if (fb)
            begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

endpackage

/* tb/frc_checker.sv */
`timescale 1ns / 100ps

module frc_checker
    import frc_pkg::*;
    import frc_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    input  logic        rx_ready,
    input  logic [7:0]  rx_byte,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  byte_index,
    input  logic        frame_end,
    input  logic [1:0]  frame_status,
    output int unsigned fail_count,
    output int unsigned pending
);

    localparam int unsigned REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        HUNT,
        SKIP_MARKS,
        COLLECT
    } rx_phase_t;

    typedef struct packed {
        logic [7:0]  data;
        logic [7:0]  index;
        logic        last;
        frc_status_t status;
    } echo_t;

    echo_t       echo_q[$];
    rx_phase_t   rx_phase;
    logic [7:0]  frame_len;
    logic [7:0]  next_index;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo_rx;
    logic [7:0]  crc_hi_rx;

    // one frame byte: CRC/trailer capture, echo and end-of-frame status
    task automatic capture_byte(input logic [7:0] b);
        int unsigned idx;
        int unsigned len;
        int unsigned span;
        echo_t       e;
        idx  = next_index;
        len  = frame_len;
        span = (len == 0 || len > MAX_LEN) ? MAX_LEN : len;
        if (idx + 4 < len)
        begin
            crc_acc = crc16_update(crc_acc, b);
        end
        if (len >= MIN_CRC_LEN && idx == len - 3)
        begin
            crc_lo_rx = b;
        end
        if (len >= MIN_CRC_LEN && idx == len - 2)
        begin
            crc_hi_rx = b;
        end
        e.data   = b;
        e.index  = idx[7:0];
        e.last   = (idx + 1 >= span);
        e.status = ST_OK;
        if (e.last)
        begin
            if (len > MAX_LEN)
            begin
                e.status = ST_TOO_LONG;
            end
            else if (len < MIN_CRC_LEN)
            begin
                e.status = ST_TOO_SHORT;
            end
            else if ({crc_hi_rx, crc_lo_rx} != crc_acc)
            begin
                e.status = ST_CRC_BAD;
            end
            rx_phase   = HUNT;
            next_index = 8'd0;
        end
        else
        begin
            next_index = 8'(idx + 1);
        end
        echo_q.push_back(e);
    endtask

    task automatic predict_rx_byte(input logic [7:0] b);
        case (rx_phase)
            SKIP_MARKS:
            begin
                if (b != START_MARK)
                begin
                    frame_len  = b;
                    next_index = 8'd0;
                    crc_acc    = CRC_INIT;
                    crc_lo_rx  = 8'd0;
                    crc_hi_rx  = 8'd0;
                    rx_phase   = COLLECT;
                    capture_byte(b);
                end
            end
            COLLECT:
            begin
                capture_byte(b);
            end
            default:
            begin
                rx_phase = (b == START_MARK) ? SKIP_MARKS : HUNT;
            end
        endcase
    endtask

    task automatic check_echo();
        echo_t e;
        if (echo_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
            begin
                $display("unexpected result: data %02h index %0d end %0b status %0d",
                         data_byte, byte_index, frame_end, frame_status);
            end
        end
        else
        begin
            e = echo_q.pop_front();
            if (data_byte !== e.data || byte_index !== e.index ||
                frame_end !== e.last || frame_status !== e.status)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("mismatch: exp data %02h index %0d end %0b status %0d",
                             e.data, e.index, e.last, e.status);
                    $display("          got data %02h index %0d end %0b status %0d",
                             data_byte, byte_index, frame_end, frame_status);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase   = HUNT;
            frame_len  = 8'd0;
            next_index = 8'd0;
            crc_acc    = CRC_INIT;
            crc_lo_rx  = 8'd0;
            crc_hi_rx  = 8'd0;
            echo_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (rx_valid && rx_ready)
            begin
                predict_rx_byte(rx_byte);
            end
            if (res_valid && res_ready)
            begin
                check_echo();
            end
            pending = echo_q.size();
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    import frc_pkg::*;
    import frc_tb_pkg::*;

    // random frame bytes to offer after the directed part
    localparam int unsigned RANDOM_ITEMS = 1000;
    // final stretch of the random part runs with no idling on either side
    localparam int unsigned CALM_TAIL    = 150;
    // long result-side hold so the skid register fills and rx stalls
    localparam int unsigned LONG_HOLD    = 80;
    // margin after the drain; give spurious results time to show
    localparam int unsigned DRAIN_CYCLES = 16;
    // ~1300 rx transactions, each at worst a send gap plus a result stall, plus the
    // long hold; the limit takes several times that
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        rx_valid  = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_byte   = 8'h00;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic        frame_end;
    logic [1:0]  frame_status;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count  = 0;
    int unsigned frame_bytes  = 0;
    bit          no_idle      = 1'b0;
    bit          hold_request = 1'b0;
    bit          hold_active  = 1'b0;

    frame_receiver_crc_checker_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .frame_end    (frame_end),
        .frame_status (frame_status)
    );

    // watches both channels, predicts every echo and compares
    frc_checker frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .frame_end    (frame_end),
        .frame_status (frame_status),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drop valid and sit out the requested idle stretch. Always advances time, so a following
    // transaction never raises valid in the same step it was lowered.
    task automatic rx_idle(input int unsigned n);
        rx_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // One rx transaction. Valid stays high from one byte to the next unless a
    // random gap is taken first; returns in the step the byte was accepted.
    task automatic send_rx(input logic [7:0] b);
        if (!no_idle && $urandom_range(0, 9) == 0)
        begin
            rx_idle($urandom_range(1, 19));
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Start markers then a whole frame. Byte 0 is the length; for lengths the
    // block checks, the CRC over bytes 0..L-5 lands at L-3 (low) and L-2 (high),
    // with one bit flipped when a bad CRC is wanted. Data carries the odd '$'
    // so that markers inside a frame are seen as plain data.
    task automatic send_frame(input logic [7:0] len, input int unsigned marks,
                              input bit good_crc, input bit mark_inside);
        logic [7:0]  body [0:MAX_LEN-1];
        int unsigned span;
        int unsigned flip_at;
        logic [15:0] crc;
        span    = (len == 0 || len > MAX_LEN) ? MAX_LEN : len;
        body[0] = len;
        for (int i = 1; i < span; i++)
        begin
            body[i] = ($urandom_range(0, 7) == 0) ? START_MARK : 8'($urandom_range(0, 255));
        end
        if (mark_inside && span > 1)
        begin
            body[1] = START_MARK;
        end
        if (len >= MIN_CRC_LEN && len <= MAX_LEN)
        begin
            crc = CRC_INIT;
            for (int i = 0; i + 4 < len; i++)
            begin
                crc = crc16_update(crc, body[i]);
            end
            body[len - 3] = crc[7:0];
            body[len - 2] = crc[15:8];
            if (!good_crc)
            begin
                flip_at       = len - 3 + $urandom_range(0, 1);
                body[flip_at] = body[flip_at] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        repeat (marks) send_rx(START_MARK);
        for (int i = 0; i < span; i++)
        begin
            send_rx(body[i]);
            frame_bytes++;
        end
    endtask

    // Result side: random ready stretches and stall bursts, plus one long hold
    // on request from the stimulus. Calm tail keeps ready high.
    initial
    begin : result_sink
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                res_ready   <= 1'b0;
                hold_active  = 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
                hold_active  = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0]  len;
        int unsigned pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // stray bytes while hunting, field extremes among them: no echo
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(8'h5A);
        // shortest checked frame behind a run of repeated markers
        send_frame(MIN_CRC_LEN, 3, 1'b1, 1'b0);
        // '$' as frame data
        send_frame(8'd9, 1, 1'b1, 1'b1);
        // CRC mismatch
        send_frame(8'd7, 1, 1'b0, 1'b0);
        // length one: a lone byte, too short
        send_frame(8'd1, 1, 1'b1, 1'b0);
        // length four: too short, no CRC compare
        send_frame(8'd4, 2, 1'b1, 1'b0);
        // length zero: full MAX_LEN bytes, too short
        send_frame(8'd0, 1, 1'b1, 1'b0);
        // length over the maximum, both just over and at the top of the range
        send_frame(8'd255, 1, 1'b1, 1'b0);
        send_frame(8'(MAX_LEN + 1), 1, 1'b1, 1'b0);
        // longest good frame
        send_frame(8'(MAX_LEN), 1, 1'b1, 1'b0);

        // sender pauses until every echo so far is back
        rx_idle(1);
        while (pending != 0)
        begin
            @(posedge clk);
        end

        // back-pressure: result side holds off while a gapless frame is
        // offered, so the skid register fills and rx_ready must drop
        hold_request = 1'b1;
        while (!hold_active)
        begin
            @(posedge clk);
        end
        no_idle = 1'b1;
        send_frame(8'(MAX_LEN), 1, 1'b1, 1'b0);
        no_idle = 1'b0;

        // ---- random part ----
        // Mostly well-formed frames with random content; some odd lengths and
        // stray bytes, which can also open or break up a frame.
        frame_bytes = 0;
        while (frame_bytes < RANDOM_ITEMS)
        begin
            if (frame_bytes >= RANDOM_ITEMS - CALM_TAIL)
            begin
                no_idle = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(0, 255)));
            end
            else if (pick < 14)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    len = 8'd0;
                end
                else
                begin
                    len = 8'($urandom_range(MAX_LEN + 1, 255));
                end
                send_frame(len, $urandom_range(1, 3), 1'b1, 1'b0);
            end
            else if (pick < 20)
            begin
                len = 8'($urandom_range(1, MIN_CRC_LEN - 1));
                send_frame(len, $urandom_range(1, 3), 1'b1, 1'b0);
            end
            else
            begin
                len = 8'($urandom_range(MIN_CRC_LEN, MAX_LEN));
                send_frame(len, $urandom_range(1, 3), pick >= 32, 1'b0);
            end
        end

        // drain, then wait out the drain margin to catch any stray result
        rx_idle(1);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/frc_pkg.sv
rtl/core/frc_frame_fsm.sv
rtl/core/frame_receiver_crc_checker_unit.sv
tb/frc_tb_pkg.sv
tb/frc_checker.sv
tb/tb_top.sv
